>>> sv/tpsc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpsc_pkg
// Types, constants and the divider step shared by the two-point calibration
// pipeline.
// ----------------------------------------------------------------------------
package tpsc_pkg;

  // Command codes.
  localparam logic CMD_TEMP = 1'b0;
  localparam logic CMD_HUM  = 1'b1;

  // Calibration register indexes.
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_T_LO_PT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_T_HI_PT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_T_LO_RAW = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_T_HI_RAW = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_H_LO_PT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_H_HI_PT  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_H_LO_RAW = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_H_HI_RAW = 3'd7;
  localparam int unsigned CFG_DATA_W = 16;

  // Numerator magnitude stays below 2**27, divisor magnitude below 2**16.
  localparam int unsigned NUM_W = 27;
  localparam int unsigned DEN_W = 16;

  // Quotient bits resolved per divider stage, and the number of stages.
  localparam int unsigned DIV_STEPS  = 3;
  localparam int unsigned DIV_STAGES = NUM_W / DIV_STEPS;

  // Front end stages, divider stages and the output register.
  localparam int unsigned FRONT_STAGES = 4;
  localparam int unsigned LATENCY      = FRONT_STAGES + DIV_STAGES + 1;

  // Saturation limits.
  localparam logic signed [NUM_W:0] TEMP_MAX = 28'sd32767;
  localparam logic signed [NUM_W:0] TEMP_MIN = -28'sd32768;
  localparam logic signed [NUM_W:0] HUM_MAX  = 28'sd100;
  localparam logic signed [NUM_W:0] HUM_MIN  = 28'sd0;

  typedef struct packed {
    logic [9:0]  t_lo_pt;
    logic [9:0]  t_hi_pt;
    logic [15:0] t_lo_raw;
    logic [15:0] t_hi_raw;
    logic [7:0]  h_lo_pt;
    logic [7:0]  h_hi_pt;
    logic [15:0] h_lo_raw;
    logic [15:0] h_hi_raw;
  } cal_set_t;

  // One item in flight through the divider. nq holds the numerator bits not
  // yet consumed in its upper part and the quotient bits in its lower part.
  typedef struct packed {
    logic             cmd;
    logic             err;
    logic             neg;
    logic [DEN_W-1:0] dvs;
    logic [DEN_W-1:0] rem;
    logic [NUM_W-1:0] nq;
  } div_op_t;

  // One restoring division step.
  function automatic div_op_t div_step(div_op_t op);
    logic [DEN_W:0] trial;
    div_op_t        res;
    res = op;
    trial = {op.rem, op.nq[NUM_W-1]};
    res.nq = {op.nq[NUM_W-2:0], 1'b0};
    if (trial >= {1'b0, op.dvs}) begin
      res.rem = DEN_W'(trial - {1'b0, op.dvs});
      res.nq[0] = 1'b1;
    end else begin
      res.rem = trial[DEN_W-1:0];
    end
    return res;
  endfunction

endpackage
`default_nettype wire

>>> sv/tpsc_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpsc_cfg_regs
// Calibration point registers, written through a plain write port.
// ----------------------------------------------------------------------------
module tpsc_cfg_regs
  import tpsc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output cal_set_t                   cal
);

  cal_set_t cal_r;
  cal_set_t cal_nxt;

  always_comb begin
    cal_nxt = cal_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_T_LO_PT:  cal_nxt.t_lo_pt  = cfg_data[9:0];
        REG_T_HI_PT:  cal_nxt.t_hi_pt  = cfg_data[9:0];
        REG_T_LO_RAW: cal_nxt.t_lo_raw = cfg_data;
        REG_T_HI_RAW: cal_nxt.t_hi_raw = cfg_data;
        REG_H_LO_PT:  cal_nxt.h_lo_pt  = cfg_data[7:0];
        REG_H_HI_PT:  cal_nxt.h_hi_pt  = cfg_data[7:0];
        REG_H_LO_RAW: cal_nxt.h_lo_raw = cfg_data;
        REG_H_HI_RAW: cal_nxt.h_hi_raw = cfg_data;
        default:      cal_nxt = cal_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_r <= '0;
    end else begin
      cal_r <= cal_nxt;
    end
  end

  assign cal = cal_r;

endmodule
`default_nettype wire

>>> sv/tpsc_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpsc_front
// Selects the calibration pair, forms the interpolation numerator and
// denominator, and splits them into sign and magnitude for the divider.
// ----------------------------------------------------------------------------
module tpsc_front
  import tpsc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic               in_command,
  input  wire logic signed [15:0] in_raw_sample,
  input  wire cal_set_t           cal,
  output logic                    op_valid,
  output div_op_t                 op
);

  logic signed [10:0] p0;
  logic signed [10:0] p1;
  logic signed [15:0] r0;
  logic signed [15:0] r1;

  // Stage A: differences.
  logic               vld_a_r;
  logic               cmd_a_r;
  logic signed [10:0] p0_a_r;
  logic signed [10:0] dp_a_r;
  logic signed [16:0] dr_a_r;
  logic signed [16:0] den_a_r;
  logic signed [10:0] dp_a_nxt;
  logic signed [16:0] dr_a_nxt;
  logic signed [16:0] den_a_nxt;

  // Stage B: products.
  logic                 vld_b_r;
  logic                 cmd_b_r;
  logic signed [16:0]   den_b_r;
  logic signed [NUM_W:0] prod0_b_r;
  logic signed [NUM_W:0] prod1_b_r;
  logic signed [NUM_W:0] prod0_b_nxt;
  logic signed [NUM_W:0] prod1_b_nxt;

  // Stage C: numerator.
  logic                  vld_c_r;
  logic                  cmd_c_r;
  logic signed [16:0]    den_c_r;
  logic signed [NUM_W:0] num_c_r;
  logic signed [NUM_W:0] num_c_nxt;

  // Stage D: sign and magnitude.
  logic    vld_d_r;
  div_op_t op_d_r;
  div_op_t op_d_nxt;

  always_comb begin
    if (in_command == CMD_HUM) begin
      // Humidity points are kept in half percent; work in whole percent.
      p0 = {4'b0, cal.h_lo_pt[7:1]};
      p1 = {4'b0, cal.h_hi_pt[7:1]};
      r0 = cal.h_lo_raw;
      r1 = cal.h_hi_raw;
    end else begin
      p0 = {1'b0, cal.t_lo_pt};
      p1 = {1'b0, cal.t_hi_pt};
      r0 = cal.t_lo_raw;
      r1 = cal.t_hi_raw;
    end
    dp_a_nxt  = p1 - p0;
    dr_a_nxt  = 17'(in_raw_sample) - 17'(r0);
    den_a_nxt = 17'(r1) - 17'(r0);
  end

  always_comb begin
    prod0_b_nxt = 28'(p0_a_r) * 28'(den_a_r);
    prod1_b_nxt = 28'(dp_a_r) * 28'(dr_a_r);
  end

  assign num_c_nxt = prod0_b_r + prod1_b_r;

  always_comb begin
    op_d_nxt.cmd = cmd_c_r;
    op_d_nxt.err = (den_c_r == 17'sd0);
    op_d_nxt.neg = num_c_r[NUM_W] ^ den_c_r[16];
    op_d_nxt.dvs = den_c_r[16] ? DEN_W'(-den_c_r) : den_c_r[DEN_W-1:0];
    op_d_nxt.rem = '0;
    op_d_nxt.nq  = num_c_r[NUM_W] ? NUM_W'(-num_c_r) : num_c_r[NUM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
      vld_c_r <= 1'b0;
      vld_d_r <= 1'b0;
    end else begin
      vld_a_r <= in_valid;
      vld_b_r <= vld_a_r;
      vld_c_r <= vld_b_r;
      vld_d_r <= vld_c_r;
    end
  end

  always_ff @(posedge clk) begin
    cmd_a_r   <= in_command;
    p0_a_r    <= p0;
    dp_a_r    <= dp_a_nxt;
    dr_a_r    <= dr_a_nxt;
    den_a_r   <= den_a_nxt;
    cmd_b_r   <= cmd_a_r;
    den_b_r   <= den_a_r;
    prod0_b_r <= prod0_b_nxt;
    prod1_b_r <= prod1_b_nxt;
    cmd_c_r   <= cmd_b_r;
    den_c_r   <= den_b_r;
    num_c_r   <= num_c_nxt;
    op_d_r    <= op_d_nxt;
  end

  assign op_valid = vld_d_r;
  assign op       = op_d_r;

endmodule
`default_nettype wire

>>> sv/tpsc_div_pipe.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpsc_div_pipe
// Pipelined restoring divider on magnitudes: each stage resolves a few
// quotient bits, and one item can enter every cycle.
// ----------------------------------------------------------------------------
module tpsc_div_pipe
  import tpsc_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  input  wire div_op_t in_op,
  output logic         out_valid,
  output div_op_t      out_op
);

  logic [DIV_STAGES-1:0] vld_r;
  div_op_t               stg_r   [DIV_STAGES];
  div_op_t               stg_nxt [DIV_STAGES];
  div_op_t               src     [DIV_STAGES];

  assign src[0] = in_op;

  for (genvar g = 1; g < DIV_STAGES; g++) begin : g_link
    assign src[g] = stg_r[g-1];
  end

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
    always_comb begin
      stg_nxt[g] = src[g];
      for (int k = 0; k < DIV_STEPS; k++) begin
        stg_nxt[g] = div_step(stg_nxt[g]);
      end
    end

    always_ff @(posedge clk) begin
      stg_r[g] <= stg_nxt[g];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[DIV_STAGES-2:0], in_valid};
    end
  end

  assign out_valid = vld_r[DIV_STAGES-1];
  assign out_op    = stg_r[DIV_STAGES-1];

endmodule
`default_nettype wire

>>> sv/tpsc_finish.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpsc_finish
// Applies the sign to the quotient, saturates to the range of the selected
// quantity (or gives zero on a calibration error) and registers the result.
// ----------------------------------------------------------------------------
module tpsc_finish
  import tpsc_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  input  wire div_op_t      in_op,
  output logic              out_strobe,
  output logic signed [15:0] out_value,
  output logic              out_calib_error
);

  logic signed [NUM_W:0] q_s;
  logic                  strobe_r;
  logic signed [15:0]    value_r;
  logic signed [15:0]    value_nxt;
  logic                  err_r;

  // Magnitude division followed by the sign gives truncation toward zero.
  assign q_s = in_op.neg ? -$signed({1'b0, in_op.nq}) : $signed({1'b0, in_op.nq});

  always_comb begin
    value_nxt = q_s[15:0];
    if (in_op.err) begin
      value_nxt = '0;
    end else if (in_op.cmd == CMD_HUM) begin
      if (q_s > HUM_MAX) begin
        value_nxt = HUM_MAX[15:0];
      end else if (q_s < HUM_MIN) begin
        value_nxt = HUM_MIN[15:0];
      end
    end else begin
      if (q_s > TEMP_MAX) begin
        value_nxt = TEMP_MAX[15:0];
      end else if (q_s < TEMP_MIN) begin
        value_nxt = TEMP_MIN[15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    err_r   <= in_op.err;
  end

  assign out_strobe      = strobe_r;
  assign out_value       = value_r;
  assign out_calib_error = err_r;

endmodule
`default_nettype wire

>>> sv/two_point_sensor_calibration_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// The result path runs through 4 front end stages, 9 divider stages of 3
// quotient bits and 1 output stage.
// Throughput: one item per cycle; busy stays low, so start is taken every cycle.
// The result is shown for one cycle under out_strobe; the receiver cannot stall.
// Synchronous active-low reset clears the calibration registers to zero and
// drops every valid bit in the pipeline.
// ----------------------------------------------------------------------------
// two_point_sensor_calibration_unit
// Two-point linear calibration of temperature and humidity samples.
// ----------------------------------------------------------------------------
module two_point_sensor_calibration_unit
  import tpsc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic                  in_command,
  input  wire logic signed [15:0]    in_raw_sample,
  output logic                       out_strobe,
  output logic signed [15:0]         out_value,
  output logic                       out_calib_error,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  cal_set_t cal;
  logic     front_valid;
  div_op_t  front_op;
  logic     div_valid;
  div_op_t  div_op;

  assign busy = 1'b0;

  tpsc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cal       (cal)
  );

  tpsc_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (start),
    .in_command    (in_command),
    .in_raw_sample (in_raw_sample),
    .cal           (cal),
    .op_valid      (front_valid),
    .op            (front_op)
  );

  tpsc_div_pipe u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (front_valid),
    .in_op     (front_op),
    .out_valid (div_valid),
    .out_op    (div_op)
  );

  tpsc_finish u_finish (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (div_valid),
    .in_op           (div_op),
    .out_strobe      (out_strobe),
    .out_value       (out_value),
    .out_calib_error (out_calib_error)
  );

endmodule
`default_nettype wire

>>> sv/tpsc_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpsc_checker
// Port-level checks of the calibration unit: fixed latency, error results
// and the humidity range.
// ----------------------------------------------------------------------------
module tpsc_checker
  import tpsc_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               start,
  input wire logic               busy,
  input wire logic               in_command,
  input wire logic               out_strobe,
  input wire logic signed [15:0] out_value,
  input wire logic               out_calib_error
);

  // Every accepted item produces its result once it has passed the whole pipeline.
  a_latency_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LATENCY out_strobe)
    else $error("accepted item produced no result after the pipeline latency");

  // No result appears without an item accepted at the matching edge.
  a_latency_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy && rst_n, LATENCY))
    else $error("result without a matching accepted item");

  // A calibration error always reports a zero value.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_calib_error) |-> (out_value == 16'sd0))
    else $error("calibration error with a nonzero value");

  // Humidity results stay within 0 to 100 percent.
  a_hum_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && $past(in_command, LATENCY))
      |-> (!out_value[15] && (out_value <= 16'sd100)))
    else $error("humidity result outside 0 to 100");

endmodule

bind two_point_sensor_calibration_unit tpsc_checker u_tpsc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .in_command      (in_command),
  .out_strobe      (out_strobe),
  .out_value       (out_value),
  .out_calib_error (out_calib_error)
);
`default_nettype wire
